FILE: design/tkbd_pkg.sv
`timescale 1ns / 1ps

package tkbd_pkg;

  // Field widths fixed by the item formats
  localparam int unsigned SampleW    = 16;
  localparam int unsigned KeyW       = 3;
  localparam int unsigned MapW       = 8;
  localparam int unsigned PctW       = 7;
  localparam int unsigned DebW       = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 7;

  // Decoupling queue between front and back
  localparam int unsigned QueueDepth = 2;

  // Threshold is a percentage of the baseline
  localparam int unsigned PercentDiv = 100;

  // Register reset values
  localparam logic [PctW-1:0] PctResetVal = 7'd10;
  localparam logic [DebW-1:0] DebResetVal = 4'd2;

  // Item commands; the unused code is treated as a query
  typedef enum logic [1:0] {
    CmdCalib = 2'd0,
    CmdScan  = 2'd1,
    CmdQuery = 2'd2
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 2'd0,
    CfgDebounce  = 2'd1
  } cfg_idx_e;

  // Input item as seen on the port
  typedef struct packed {
    logic [1:0]         command;
    logic [KeyW-1:0]    key_index;
    logic [SampleW-1:0] sample;
    logic               first_pass;
  } in_item_t;

  // Result item as seen on the port
  typedef struct packed {
    logic [KeyW-1:0]    out_key;
    logic               key_pressed;
    logic               over_threshold;
    logic [MapW-1:0]    pressed_map;
    logic [SampleW-1:0] key_baseline;
  } out_item_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic               is_cal;
    logic               is_scan;
    logic               key_ok;
    logic [KeyW-1:0]    key;
    logic [SampleW-1:0] sample;
    logic               first_pass;
  } op_t;

  // Live configuration
  typedef struct packed {
    logic [PctW-1:0] threshold_percent;
    logic [DebW-1:0] debounce_count;
  } cfg_t;

endpackage

FILE: design/tkbd_front.sv
`timescale 1ns / 1ps

module tkbd_front #(
  parameter int unsigned NUM_KEYS = 8
) (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tkbd_pkg::in_item_t   in_data_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output tkbd_pkg::op_t        push_op_o
);

  tkbd_pkg::op_t op;

  // Decode command and range-check the key
  always_comb begin
    op            = '0;
    op.key        = in_data_i.key_index;
    op.sample     = in_data_i.sample;
    op.first_pass = in_data_i.first_pass;
    op.key_ok     = (32'(in_data_i.key_index) < NUM_KEYS);
    unique case (in_data_i.command)
      tkbd_pkg::CmdCalib: op.is_cal  = 1'b1;
      tkbd_pkg::CmdScan:  op.is_scan = 1'b1;
      tkbd_pkg::CmdQuery: ;
      default:            ;  // spare code reports like a query
    endcase
  end

  // Transaction goes straight into the queue
  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;
  assign push_op_o    = op;

endmodule

FILE: design/tkbd_queue.sv
`timescale 1ns / 1ps

module tkbd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  tkbd_pkg::op_t push_op_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output tkbd_pkg::op_t pop_op_o
);

  localparam int unsigned Depth = tkbd_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  tkbd_pkg::op_t   entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_op_o     = entry_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

FILE: design/tkbd_back.sv
`timescale 1ns / 1ps

module tkbd_back #(
  parameter int unsigned NUM_KEYS    = 8,
  parameter int unsigned CAL_SAMPLES = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    op_valid_i,
  output logic                    op_ready_o,
  input  tkbd_pkg::op_t           op_i,
  input  tkbd_pkg::cfg_t          cfg_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output tkbd_pkg::out_item_t     out_data_o
);

  localparam int unsigned CalW    = $clog2(CAL_SAMPLES);
  localparam int unsigned SumW    = SAMPLE_BITS + CalW;
  localparam int unsigned RecipW  = SAMPLE_BITS + 1;
  localparam int unsigned ProdW   = SumW + RecipW;
  localparam int unsigned ThrW    = SAMPLE_BITS + tkbd_pkg::PctW;
  localparam int unsigned KeyIdxW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned OutW    = tkbd_pkg::SampleW;
  localparam int unsigned MapW    = tkbd_pkg::MapW;
  localparam int unsigned DebW    = tkbd_pkg::DebW;

  // Accumulator ceiling and reciprocal of the sample count
  localparam logic [SumW-1:0]   SumMax  = SumW'((64'(CAL_SAMPLES) << SAMPLE_BITS) - 64'd1);
  localparam logic [RecipW-1:0] RecipM  = RecipW'((64'd1 << SumW) / 64'(CAL_SAMPLES));
  localparam logic [SumW-1:0]   CalDiv  = SumW'(CAL_SAMPLES);
  localparam logic [tkbd_pkg::PctW-1:0] Hundred = tkbd_pkg::PctW'(tkbd_pkg::PercentDiv);

  typedef struct packed {
    logic                      is_cal;
    logic                      is_scan;
    logic                      key_ok;
    logic [tkbd_pkg::KeyW-1:0] key;
  } tag_t;

  // Per-key state
  logic [SumW-1:0]        sum_q   [NUM_KEYS];
  logic [SAMPLE_BITS-1:0] base_q  [NUM_KEYS];
  logic                   press_q [NUM_KEYS];
  logic [DebW-1:0]        count_q [NUM_KEYS];

  // Pipeline registers
  logic                   s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;
  tag_t                   s1_tag_q, s2_tag_q, s3_tag_q;
  logic [SumW-1:0]        s1_sum_q, s2_sum_q, s3_sum_q;
  logic [SAMPLE_BITS-1:0] s1_base_q, s2_base_q, s3_base_q;
  logic [SAMPLE_BITS-1:0] s1_diff_q;
  logic [ProdW-1:0]       s2_prod_q;
  logic [ThrW-1:0]        s2_thr_q, s2_dif_q;
  logic [SAMPLE_BITS-1:0] s3_q0_q;
  logic [SumW-1:0]        s3_q0cal_q;
  logic                   s3_over_q;
  tkbd_pkg::out_item_t    out_q;

  logic advance, hazard, issue;

  // Issue-stage signals
  tag_t                   tag1;
  logic [KeyIdxW-1:0]     idx1;
  logic [SAMPLE_BITS-1:0] smp1, base1, diff1;
  logic [SumW-1:0]        sum_rd1, sum_old1, sum1;
  logic [SumW:0]          sum_ext1;

  // Commit-stage signals
  logic [KeyIdxW-1:0]     idx4;
  logic [SumW-1:0]        rem4;
  logic [SAMPLE_BITS-1:0] cal_base4, base4;
  logic                   press_old4, press_new4;
  logic [DebW-1:0]        cnt_old4, cnt_inc4, cnt_new4;
  logic [MapW-1:0]        map4;
  logic                   commit;
  tkbd_pkg::out_item_t    res4;

  // Pipeline moves whenever the output slot is free or being drained
  assign advance = !out_vld_q || out_ready_i;

  // A baseline reader waits for an in-flight calibrate of the same key
  always_comb begin
    hazard = 1'b0;
    if (!op_i.is_cal && op_i.key_ok) begin
      hazard = (s1_vld_q && s1_tag_q.is_cal && s1_tag_q.key_ok && s1_tag_q.key == op_i.key)
            || (s2_vld_q && s2_tag_q.is_cal && s2_tag_q.key_ok && s2_tag_q.key == op_i.key)
            || (s3_vld_q && s3_tag_q.is_cal && s3_tag_q.key_ok && s3_tag_q.key == op_i.key);
    end
  end

  assign op_ready_o = advance && !hazard;
  assign issue      = op_valid_i && op_ready_o;

  // Issue: accumulate, read baseline, absolute deviation
  always_comb begin
    tag1.is_cal  = op_i.is_cal;
    tag1.is_scan = op_i.is_scan;
    tag1.key_ok  = op_i.key_ok;
    tag1.key     = op_i.key;
    idx1     = KeyIdxW'(op_i.key);
    smp1     = SAMPLE_BITS'(op_i.sample);
    base1    = op_i.key_ok ? base_q[idx1] : '0;
    sum_rd1  = op_i.key_ok ? sum_q[idx1] : '0;
    sum_old1 = op_i.first_pass ? '0 : sum_rd1;
    sum_ext1 = (SumW+1)'(sum_old1) + (SumW+1)'(smp1);
    sum1     = (sum_ext1 > (SumW+1)'(SumMax)) ? SumMax : sum_ext1[SumW-1:0];
    diff1    = (smp1 >= base1) ? smp1 - base1 : base1 - smp1;
  end

  // Commit: finish the division, debounce, build the result
  always_comb begin
    idx4       = KeyIdxW'(s3_tag_q.key);
    rem4       = s3_sum_q - s3_q0cal_q;
    cal_base4  = s3_q0_q + SAMPLE_BITS'(rem4 >= CalDiv);
    base4      = s3_tag_q.is_cal ? cal_base4 : s3_base_q;
    press_old4 = s3_tag_q.key_ok ? press_q[idx4] : 1'b0;
    cnt_old4   = s3_tag_q.key_ok ? count_q[idx4] : '0;
    cnt_inc4   = cnt_old4 + DebW'(1);
    press_new4 = press_old4;
    cnt_new4   = cnt_old4;
    if (s3_tag_q.is_scan && s3_tag_q.key_ok) begin
      if (s3_over_q == press_old4) begin
        cnt_new4 = '0;
      end else if (cnt_inc4 >= cfg_i.debounce_count) begin
        press_new4 = s3_over_q;
        cnt_new4   = '0;
      end else begin
        cnt_new4 = cnt_inc4;
      end
    end
  end

  // Pressed map after this transaction
  for (genvar k = 0; k < MapW; k++) begin : g_map
    if (k < NUM_KEYS) begin : g_on
      assign map4[k] = (s3_tag_q.key_ok && idx4 == KeyIdxW'(k)) ? press_new4 : press_q[k];
    end else begin : g_off
      assign map4[k] = 1'b0;
    end
  end

  always_comb begin
    res4.out_key        = s3_tag_q.key;
    res4.key_pressed    = s3_tag_q.key_ok && press_new4;
    res4.over_threshold = s3_tag_q.key_ok && s3_tag_q.is_scan && s3_over_q;
    res4.pressed_map    = map4;
    res4.key_baseline   = s3_tag_q.key_ok ? OutW'(base4) : '0;
  end

  assign commit = s3_vld_q && advance;

  // Valid bits through the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      s1_vld_q  <= issue;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      out_vld_q <= s3_vld_q;
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_tag_q   <= tag1;
      s1_sum_q   <= sum1;
      s1_base_q  <= base1;
      s1_diff_q  <= diff1;

      s2_tag_q   <= s1_tag_q;
      s2_sum_q   <= s1_sum_q;
      s2_base_q  <= s1_base_q;
      s2_prod_q  <= ProdW'(s1_sum_q) * ProdW'(RecipM);
      s2_thr_q   <= ThrW'(s1_base_q) * ThrW'(cfg_i.threshold_percent);
      s2_dif_q   <= ThrW'(s1_diff_q) * ThrW'(Hundred);

      s3_tag_q   <= s2_tag_q;
      s3_sum_q   <= s2_sum_q;
      s3_base_q  <= s2_base_q;
      s3_q0_q    <= s2_prod_q[SumW +: SAMPLE_BITS];
      s3_q0cal_q <= SumW'(s2_prod_q[SumW +: SAMPLE_BITS]) * CalDiv;
      s3_over_q  <= (s2_dif_q > s2_thr_q);

      if (s3_vld_q) begin
        out_q <= res4;
      end
    end
  end

  // Per-key state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        sum_q[k]   <= '0;
        base_q[k]  <= '0;
        press_q[k] <= 1'b0;
        count_q[k] <= '0;
      end
    end else begin
      if (issue && op_i.is_cal && op_i.key_ok) begin
        sum_q[idx1] <= sum1;
      end
      if (commit && s3_tag_q.key_ok) begin
        press_q[idx4] <= press_new4;
        count_q[idx4] <= cnt_new4;
        if (s3_tag_q.is_cal) begin
          base_q[idx4] <= cal_base4;
        end
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // Reciprocal quotient is at most one short of the true quotient
  a_recip_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_vld_q && s3_tag_q.is_cal |-> (SumW+1)'(rem4) < (SumW+1)'(2 * CAL_SAMPLES))
    else $error("baseline quotient estimate off by more than one");

  // A baseline reader reaching commit saw the current baseline
  a_base_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_vld_q && !s3_tag_q.is_cal && s3_tag_q.key_ok |-> s3_base_q == base_q[idx4])
    else $error("stale baseline used by scan or query");

  // A held result blocks issue, and the pipeline keeps its contents
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |=> $stable(s3_vld_q) && $stable(s1_vld_q) && out_vld_q)
    else $error("pipeline moved while the result was stalled");
`endif

endmodule

FILE: design/touch_key_baseline_debounce_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_ready_o  in_data_i  (tkbd_pkg::in_item_t)
// out      output     out_valid_o/out_ready_i out_data_o (tkbd_pkg::out_item_t)
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One transaction per cycle sustained unless an output stall or hazard holds issue; a result
// passes the queue, s1, s2, s3 and output registers. A scan or query right behind a calibrate
// of the same key reads the new baseline only after it leaves the 3-stage reciprocal divide.
// Reset (rst_ni low, asynchronous) clears all key state and restores the registers.
// A stalled output freezes the back pipeline; the 2-entry queue keeps taking input until full.

module touch_key_baseline_debounce_top #(
  parameter int unsigned NUM_KEYS    = 8,
  parameter int unsigned CAL_SAMPLES = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  tkbd_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output tkbd_pkg::out_item_t                out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tkbd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [tkbd_pkg::CfgDataW-1:0]      cfg_data_i
);

  tkbd_pkg::cfg_t cfg_q;
  tkbd_pkg::op_t  push_op, pop_op;
  logic           push_valid, push_ready, pop_valid, pop_ready;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_percent <= tkbd_pkg::PctResetVal;
      cfg_q.debounce_count    <= tkbd_pkg::DebResetVal;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tkbd_pkg::CfgThreshold: cfg_q.threshold_percent <= cfg_data_i[tkbd_pkg::PctW-1:0];
        tkbd_pkg::CfgDebounce:  cfg_q.debounce_count    <= cfg_data_i[tkbd_pkg::DebW-1:0];
        default:                ;
      endcase
    end
  end

  // Front: decode and classify
  tkbd_front #(
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_op_o    (push_op)
  );

  // Queue between front and back
  tkbd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_op_i    (push_op),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_op_o     (pop_op)
  );

  // Back: baseline, threshold and debounce pipeline
  tkbd_back #(
    .NUM_KEYS    (NUM_KEYS),
    .CAL_SAMPLES (CAL_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (pop_valid),
    .op_ready_o  (pop_ready),
    .op_i        (pop_op),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: bench/tb_touch_key_baseline_debounce_top.sv
`timescale 1ns / 1ps

module tb_touch_key_baseline_debounce_top;
  import tkbd_pkg::*;

  // Spare command code, treated by the block as a query
  localparam logic [1:0] CmdSpare = 2'd3;

  localparam int unsigned NumKeys    = 8;
  localparam int unsigned SumMax     = 20'hFFFFF;
  localparam int unsigned NumSegs    = 9;
  localparam int unsigned SegItems   = 211;
  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned DrainWait  = 8;

  // Directed stimulus row; want is only used when typed is set
  typedef struct packed {
    in_item_t  item;
    logic [4:0] reps;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  localparam int unsigned NDir = 21;
  localparam dir_row_t DirTab [NDir] = '{
    // reset state
    '{'{CmdQuery, 3'd0, 16'h0000, 1'b0}, 5'd1,  1'b1, '{3'd0, 1'b0, 1'b0, 8'h00, 16'd0}},
    // zero baseline: any nonzero sample is over, press after two scans
    '{'{CmdScan,  3'd7, 16'h0000, 1'b0}, 5'd1,  1'b1, '{3'd7, 1'b0, 1'b0, 8'h00, 16'd0}},
    '{'{CmdScan,  3'd7, 16'hFFFF, 1'b1}, 5'd1,  1'b1, '{3'd7, 1'b0, 1'b1, 8'h00, 16'd0}},
    '{'{CmdScan,  3'd7, 16'h0001, 1'b0}, 5'd1,  1'b1, '{3'd7, 1'b1, 1'b1, 8'h80, 16'd0}},
    '{'{CmdSpare, 3'd7, 16'hFFFF, 1'b1}, 5'd1,  1'b1, '{3'd7, 1'b1, 1'b0, 8'h80, 16'd0}},
    // accumulator saturation at full scale
    '{'{CmdCalib, 3'd3, 16'hFFFF, 1'b1}, 5'd1,  1'b1, '{3'd3, 1'b0, 1'b0, 8'h80, 16'd4095}},
    '{'{CmdCalib, 3'd3, 16'hFFFF, 1'b0}, 5'd16, 1'b0, '0},
    '{'{CmdQuery, 3'd3, 16'h0000, 1'b0}, 5'd1,  1'b1, '{3'd3, 1'b0, 1'b0, 8'h80, 16'd65535}},
    '{'{CmdScan,  3'd3, 16'hFFFF, 1'b0}, 5'd1,  1'b1, '{3'd3, 1'b0, 1'b0, 8'h80, 16'd65535}},
    '{'{CmdScan,  3'd3, 16'h0000, 1'b0}, 5'd1,  1'b1, '{3'd3, 1'b0, 1'b1, 8'h80, 16'd65535}},
    // baseline 100, threshold 10: exact boundary and counter clear
    '{'{CmdCalib, 3'd0, 16'd1600, 1'b1}, 5'd1,  1'b1, '{3'd0, 1'b0, 1'b0, 8'h80, 16'd100}},
    '{'{CmdScan,  3'd0, 16'd110,  1'b0}, 5'd1,  1'b1, '{3'd0, 1'b0, 1'b0, 8'h80, 16'd100}},
    '{'{CmdScan,  3'd0, 16'd89,   1'b0}, 5'd1,  1'b1, '{3'd0, 1'b0, 1'b1, 8'h80, 16'd100}},
    '{'{CmdScan,  3'd0, 16'd90,   1'b0}, 5'd1,  1'b1, '{3'd0, 1'b0, 1'b0, 8'h80, 16'd100}},
    '{'{CmdScan,  3'd0, 16'd89,   1'b0}, 5'd1,  1'b1, '{3'd0, 1'b0, 1'b1, 8'h80, 16'd100}},
    '{'{CmdScan,  3'd0, 16'd111,  1'b0}, 5'd1,  1'b1, '{3'd0, 1'b1, 1'b1, 8'h81, 16'd100}},
    // recalibrate to zero right before scans of the same key, then release
    '{'{CmdCalib, 3'd0, 16'h0000, 1'b1}, 5'd1,  1'b1, '{3'd0, 1'b1, 1'b0, 8'h81, 16'd0}},
    '{'{CmdScan,  3'd0, 16'h0000, 1'b0}, 5'd1,  1'b1, '{3'd0, 1'b1, 1'b0, 8'h81, 16'd0}},
    '{'{CmdScan,  3'd7, 16'h0000, 1'b0}, 5'd1,  1'b1, '{3'd7, 1'b1, 1'b0, 8'h81, 16'd0}},
    '{'{CmdScan,  3'd7, 16'h0000, 1'b0}, 5'd1,  1'b1, '{3'd7, 1'b0, 1'b0, 8'h01, 16'd0}},
    '{'{CmdScan,  3'd0, 16'h0000, 1'b0}, 5'd1,  1'b1, '{3'd0, 1'b0, 1'b0, 8'h00, 16'd0}}
  };

  // Register settings per random segment; segments four and seven pick their own
  localparam logic [6:0] SegPct [NumSegs] = '{
    7'd0, 7'd100, 7'd127, 7'd20, 7'd0, 7'd5, 7'd50, 7'd0, 7'd10
  };
  localparam logic [6:0] SegDeb [NumSegs] = '{
    7'h00, 7'd15, 7'h7F, 7'd1, 7'd0, 7'd3, 7'h72, 7'd0, 7'd4
  };

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Model of the key state and the live registers
  logic [19:0]        cal_acc [NumKeys];
  logic [3:0]         flip_cnt [NumKeys];
  logic [NumKeys-1:0] pressed_bits;
  logic [PctW-1:0]    pct_cfg;
  logic [DebW-1:0]    deb_cfg;

  out_item_t   key_report_q [$];
  in_item_t    touch_cmd_q [$];
  int unsigned snd_idle;
  int unsigned rcv_idle;
  int unsigned mismatches;
  int unsigned cycle_cnt;

  touch_key_baseline_debounce_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Advance the key model by one item and return the report it gives
  function automatic out_item_t predict_key_report(in_item_t it);
    out_item_t   rep;
    int unsigned k;
    logic [20:0] sum;
    logic [15:0] base;
    int unsigned diff;
    int unsigned lim;
    logic        hit;
    logic [3:0]  cnt;
    k = 32'(it.key_index);
    rep = '0;
    rep.out_key = it.key_index;
    case (it.command)
      CmdCalib: begin
        sum = (it.first_pass ? 21'd0 : {1'b0, cal_acc[k]}) + 21'(it.sample);
        if (sum > 21'(SumMax)) sum = 21'(SumMax);
        cal_acc[k] = sum[19:0];
      end
      CmdScan: begin
        base = cal_acc[k][19:4];
        diff = 32'((it.sample >= base) ? it.sample - base : base - it.sample);
        lim  = (32'(base) * 32'(pct_cfg)) / PercentDiv;
        hit  = diff > lim;
        rep.over_threshold = hit;
        if (hit == pressed_bits[k]) begin
          flip_cnt[k] = 4'd0;
        end else begin
          cnt = flip_cnt[k] + 4'd1;
          if (cnt >= deb_cfg) begin
            pressed_bits[k] = hit;
            cnt = 4'd0;
          end
          flip_cnt[k] = cnt;
        end
      end
      default: ;
    endcase
    rep.key_pressed  = pressed_bits[k];
    rep.pressed_map  = pressed_bits;
    rep.key_baseline = cal_acc[k][19:4];
    return rep;
  endfunction

  function automatic in_item_t make_item(logic [1:0] cmd, int k, logic [15:0] s, logic f);
    in_item_t it;
    it.command    = cmd;
    it.key_index  = k[2:0];
    it.sample     = s;
    it.first_pass = f;
    return it;
  endfunction

  // Sample at base +/- dev, folded back into the counter range
  function automatic logic [15:0] offset_sample(int base, int dev);
    int v;
    v = ($urandom_range(1) != 0) ? base + dev : base - dev;
    if (v > 65535) v = base - dev;
    if (v < 0) v = base + dev;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // Deviation that lands over or under the threshold, often right on the edge
  function automatic int scan_dev(logic over, int lim);
    if (over) return ($urandom_range(3) == 0) ? lim + 1 : lim + 1 + $urandom_range(lim / 2 + 40);
    return ($urandom_range(3) == 0) ? lim : $urandom_range(lim);
  endfunction

  // Queue one burst: noise, a calibration round, or a run of scans on one key
  function automatic void plan_burst();
    int unsigned kind;
    int unsigned mode;
    int          k;
    int          n;
    int          center;
    int          lim;
    logic        want_over;
    kind = $urandom_range(99);
    k    = $urandom_range(NumKeys - 1);
    if (kind < 12) begin
      n = $urandom_range(1, 4);
      repeat (n) touch_cmd_q.push_back(make_item(2'($urandom_range(3)),
                                                 $urandom_range(NumKeys - 1),
                                                 16'($urandom_range(16'hFFFF)),
                                                 1'($urandom_range(1))));
    end else if (kind < 32) begin
      mode = $urandom_range(5);
      case (mode)
        0: begin center = 65535 - $urandom_range(255); n = $urandom_range(16, 20); end
        1: begin center = $urandom_range(300); n = 16; end
        2: begin center = $urandom_range(200, 40000); n = $urandom_range(1, 15); end
        3: begin center = $urandom_range(65535); n = $urandom_range(1, 8); end
        default: begin center = $urandom_range(200, 40000); n = 16; end
      endcase
      for (int i = 0; i < n; i++) begin
        touch_cmd_q.push_back(make_item(CmdCalib, k,
                                        offset_sample(center, $urandom_range(center / 64 + 1)),
                                        (i == 0) && (mode != 3)));
      end
      // read back the fresh baseline right behind the last calibrate
      touch_cmd_q.push_back(make_item(($urandom_range(1) != 0) ? CmdScan : CmdQuery, k,
                                      offset_sample(center, $urandom_range(center / 8 + 2)),
                                      1'($urandom_range(1))));
    end else begin
      lim = (int'(cal_acc[k][19:4]) * int'(pct_cfg)) / int'(PercentDiv);
      want_over = 1'($urandom_range(1));
      n = $urandom_range(1, int'(deb_cfg) + 3);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 8) begin
          touch_cmd_q.push_back(make_item(($urandom_range(1) != 0) ? CmdQuery : CmdSpare, k,
                                          16'($urandom_range(16'hFFFF)),
                                          1'($urandom_range(1))));
        end else begin
          // an occasional opposite scan breaks the debounce run
          touch_cmd_q.push_back(make_item(CmdScan, k,
              offset_sample(int'(cal_acc[k][19:4]),
                            scan_dev(($urandom_range(99) < 6) ? !want_over : want_over, lim)),
              1'($urandom_range(1))));
        end
      end
    end
  endfunction

  // Drive one item and record its expected report on acceptance
  task automatic send_item(in_item_t it, logic typed, out_item_t want);
    out_item_t pred;
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    pred = predict_key_report(it);
    key_report_q.push_back(typed ? want : pred);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgThreshold: pct_cfg = val;
      CfgDebounce:  deb_cfg = val[DebW-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    while (key_report_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_error(string what, out_item_t want, out_item_t got);
    if (mismatches < 10) begin
      $display("%0s: exp key=%0d pr=%0b ov=%0b map=%02h base=%0d",
               what, want.out_key, want.key_pressed, want.over_threshold,
               want.pressed_map, want.key_baseline);
      $display("    got key=%0d pr=%0b ov=%0b map=%02h base=%0d",
               got.out_key, got.key_pressed, got.over_threshold,
               got.pressed_map, got.key_baseline);
    end
    mismatches++;
  endtask

  // Stimulus: directed table, then random segments under changing settings
  initial begin : stim
    int unsigned sent;
    logic [6:0]  pct_w;
    logic [6:0]  deb_w;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    snd_idle    = 13;
    rcv_idle    = 82;
    mismatches  = 0;
    for (int k = 0; k < NumKeys; k++) begin
      cal_acc[k]  = '0;
      flip_cnt[k] = '0;
    end
    pressed_bits = '0;
    pct_cfg      = PctResetVal;
    deb_cfg      = DebResetVal;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < NDir; r++) begin
      repeat (DirTab[r].reps) send_item(DirTab[r].item, DirTab[r].typed, DirTab[r].want);
    end
    in_valid_i <= 1'b0;
    wait_drain();

    for (int seg = 0; seg < NumSegs; seg++) begin
      case (seg / 3)
        0: begin snd_idle = 13; rcv_idle = 82; end
        1: begin snd_idle = 82; rcv_idle = 13; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      pct_w = SegPct[seg];
      deb_w = SegDeb[seg];
      if (seg == 4 || seg == 7) begin
        pct_w = 7'($urandom_range(127));
        deb_w = 7'($urandom_range(127));
      end
      write_reg(CfgThreshold, pct_w);
      write_reg(CfgDebounce, deb_w);
      cfg_valid_i <= 1'b0;
      sent = 0;
      touch_cmd_q.delete();
      while (sent < SegItems) begin
        if (touch_cmd_q.size() == 0) plan_burst();
        send_item(touch_cmd_q.pop_front(), 1'b0, '0);
        sent++;
      end
      in_valid_i <= 1'b0;
      wait_drain();
    end

    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("touch_key_baseline_debounce_top regression: pass");
    end else begin
      $display("touch_key_baseline_debounce_top regression: fail");
    end
    $finish;
  end

  // Result side: check each report, then pick the next ready level
  initial begin : sink
    out_item_t want;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (key_report_q.size() == 0) begin
          report_error("unexpected report", '0, out_data_o);
        end else begin
          want = key_report_q.pop_front();
          if (out_data_o.out_key != want.out_key ||
              out_data_o.key_pressed != want.key_pressed ||
              out_data_o.over_threshold != want.over_threshold ||
              out_data_o.pressed_map != want.pressed_map ||
              out_data_o.key_baseline != want.key_baseline) begin
            report_error("report mismatch", want, out_data_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Run limit
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("touch_key_baseline_debounce_top regression: fail");
    $finish;
  end

endmodule

FILE: touch_key_baseline_debounce_top.f
design/tkbd_pkg.sv
design/tkbd_front.sv
design/tkbd_queue.sv
design/tkbd_back.sv
design/touch_key_baseline_debounce_top.sv
bench/tb_touch_key_baseline_debounce_top.sv
